// ----- sv/modexp_pkg.sv -----
// ============================================================================
// modexp_pkg
// Shared widths, sequencer states and unit status for the modular
// exponentiation block.
// ============================================================================
package modexp_pkg;

    // Operand width used by the arithmetic (low bits of every field)
    localparam int WIDTH = 32;
    // Width of the fields on the ports
    localparam int FIELD_W = 32;
    // Bit counter of the shared multiplier
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // Exponentiation sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_OUT
    } state_t;

    // Status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ----- sv/modular_exponentiation.sv -----
// ============================================================================
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left binary
// square-and-multiply over one shared shift-add-reduce multiplier.
// ============================================================================
//
//  Channel   Dir  Handshake            Payload
//  s_*       in   s_tvalid / s_tready  s_tdata[31:0] base, [63:32] exponent
//  m_*       out  m_tvalid / m_tready  m_tdata[31:0] power_mod
//  cfg_*     in   cfg_wen              cfg_wdata[31:0] modulus
//
//  Each modular multiply runs in the shared unit. An item takes one base
//  reduction, one multiply per set exponent bit and one square per bit
//  below the highest set bit: at most 64 multiplies. A zero modulus skips
//  the arithmetic; a zero exponent still costs the one base reduction.
//  s_tready is high only while the sequencer is idle; a result waits in the
//  output register while the next beat is taken. Reset sets the modulus to 1.
//
module modular_exponentiation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] base, [63:32] exponent
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] power_mod
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata
);

    localparam int W  = modexp_pkg::WIDTH;
    localparam int FW = modexp_pkg::FIELD_W;

    modexp_pkg::state_t     state_reg, state_next;
    modexp_pkg::mm_status_t mm_status;

    logic [FW-1:0] modulus_reg;
    logic [W-1:0]  base_reg, base_next;
    logic [W-1:0]  exp_reg, exp_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  sq_reg, sq_next;
    logic          out_valid_reg, out_valid_next;
    logic [FW-1:0] out_data_reg, out_data_next;

    logic [W-1:0]  m_val;
    logic [W-1:0]  one_mod;
    logic [W-1:0]  exp_hi;
    logic [W-1:0]  mm_result;
    logic [W-1:0]  mm_mplier;
    logic [W-1:0]  mm_mcand;
    logic          mm_start;
    logic          accept;
    logic          out_free;

    assign m_val    = modulus_reg[W-1:0];
    assign one_mod  = (m_val == W'(1)) ? '0 : W'(1);
    assign exp_hi   = exp_reg >> 1;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Shared multiplier operands
    assign mm_mplier = (state_reg == modexp_pkg::ST_REDUCE) ? base_reg : sq_reg;
    assign mm_mcand  = (state_reg == modexp_pkg::ST_SQR) ? sq_reg : acc_reg;

    modexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .mplier  (mm_mplier),
        .mcand   (mm_mcand),
        .modulus (m_val),
        .status  (mm_status),
        .result  (mm_result)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (m_val == '0) ? modexp_pkg::ST_OUT
                                               : modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE:
            begin
                if (mm_status.done)
                begin
                    if (exp_reg[0])
                        state_next = modexp_pkg::ST_MUL;
                    else if (exp_hi == '0)
                        state_next = modexp_pkg::ST_OUT;
                    else
                        state_next = modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_MUL:
            begin
                if (mm_status.done)
                begin
                    state_next = (exp_hi == '0) ? modexp_pkg::ST_OUT
                                                : modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_SQR:
            begin
                // higher bits are known nonzero here
                if (mm_status.done)
                begin
                    state_next = exp_reg[1] ? modexp_pkg::ST_MUL
                                            : modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = modexp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath loads
    always_comb
    begin
        s_tready       = 1'b0;
        mm_start       = 1'b0;
        base_next      = base_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    base_next = s_tdata[W-1:0];
                    exp_next  = s_tdata[FW+W-1:FW];
                    acc_next  = (m_val == '0) ? '0 : one_mod;
                end
            end
            modexp_pkg::ST_REDUCE:
            begin
                mm_start = !mm_status.busy && !mm_status.done;
                if (mm_status.done)
                    sq_next = mm_result;
            end
            modexp_pkg::ST_MUL:
            begin
                mm_start = !mm_status.busy && !mm_status.done;
                if (mm_status.done)
                    acc_next = mm_result;
            end
            modexp_pkg::ST_SQR:
            begin
                mm_start = !mm_status.busy && !mm_status.done;
                if (mm_status.done)
                begin
                    sq_next  = mm_result;
                    exp_next = exp_hi;
                end
            end
            modexp_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = FW'(acc_reg);
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= FW'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
                modulus_reg <= cfg_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/modexp_mulmod.sv -----
// ============================================================================
// modexp_mulmod
// Shared modular multiplier: result = mplier * mcand mod modulus, one
// multiplier bit per cycle, most significant bit first (shift-add-reduce).
// mcand must be below modulus; mplier may be any value.
// ============================================================================
module modexp_mulmod (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [modexp_pkg::WIDTH-1:0]    mplier,
    input  logic [modexp_pkg::WIDTH-1:0]    mcand,
    input  logic [modexp_pkg::WIDTH-1:0]    modulus,
    output modexp_pkg::mm_status_t          status,
    output logic [modexp_pkg::WIDTH-1:0]    result
);

    localparam int W  = modexp_pkg::WIDTH;
    localparam int SW = modexp_pkg::WIDTH + 2;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [modexp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                   mplier_reg, mplier_next;
    logic [W-1:0]                   mcand_reg, mcand_next;
    logic [W-1:0]                   r_reg, r_next;

    logic [SW-1:0] sum;
    logic [SW-1:0] m1;
    logic [SW-1:0] m2;
    logic [SW-1:0] red;

    // One step: r = (2r + bit*mcand) mod m, sum stays below 3m
    always_comb
    begin
        m1  = SW'(modulus);
        m2  = SW'(modulus) << 1;
        sum = (SW'(r_reg) << 1) + (mplier_reg[W-1] ? SW'(mcand_reg) : '0);
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    // Step control
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        r_next      = r_reg;
        if (busy_reg)
        begin
            r_next      = red[W-1:0];
            mplier_next = mplier_reg << 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == modexp_pkg::CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start && !done_reg)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mplier_next = mplier;
            mcand_next  = mcand;
            r_next      = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        r_reg      <= r_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = r_reg;

endmodule
